@@ design/dtct_pkg.sv @@
// Package for the decode target chain tracker.
// Holds widths, the configuration register indexes and the structs shared by the modules.
// No dependencies; compile first.
package dtct_pkg;

    localparam int DATA_W      = 32;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = 6;
    localparam int MAP_W       = 48;
    localparam int NUM_MAPS    = 4;
    localparam int TGT_PER_MAP = 8;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_COUNT = 3'd0,
        REG_CHAIN_COUNT  = 3'd1,
        REG_CHAIN_MAP_0  = 3'd2,
        REG_CHAIN_MAP_1  = 3'd3,
        REG_CHAIN_MAP_2  = 3'd4,
        REG_CHAIN_MAP_3  = 3'd5
    } cfg_reg_t;

    // Configuration as the datapath sees it.
    typedef struct packed {
        logic [DATA_W-1:0]                target_mask;
        logic [DATA_W-1:0]                chain_mask;
        logic                             no_chains;
        logic [NUM_MAPS-1:0][MAP_W-1:0]   chain_map;
    } cfg_view_t;

    // One frame descriptor.
    typedef struct packed {
        logic [DATA_W-1:0] active_targets;
        logic              targets_given;
        logic              keyframe;
        logic [DATA_W-1:0] chain_membership;
    } frame_t;

    // One result item.
    typedef struct packed {
        logic [DATA_W-1:0] active_mask;
        logic [DATA_W-1:0] pending_chains;
        logic              send_mask;
    } result_t;

endpackage

@@ design/dtct_if.sv @@
// Handshake interfaces of the decode target chain tracker: frames, results, config writes.
// Depends on dtct_pkg.
interface dtct_frame_if;
    import dtct_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] active_targets;
    logic              targets_given;
    logic              keyframe;
    logic [DATA_W-1:0] chain_membership;

    modport source (output valid, output active_targets, output targets_given,
                    output keyframe, output chain_membership, input ready);
    modport sink   (input valid, input active_targets, input targets_given,
                    input keyframe, input chain_membership, output ready);
endinterface

interface dtct_result_if;
    import dtct_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] active_mask;
    logic [DATA_W-1:0] pending_chains;
    logic              send_mask;

    modport source (output valid, output active_mask, output pending_chains,
                    output send_mask, input ready);
    modport sink   (input valid, input active_mask, input pending_chains,
                    input send_mask, output ready);
endinterface

interface dtct_cfg_if;
    import dtct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MAP_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/dtct_cfg.sv @@
// Configuration register file of the decode target chain tracker.
// Presents target and chain lane masks and the chain map; depends on dtct_pkg.
module dtct_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [dtct_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [dtct_pkg::MAP_W-1:0]     wr_data,
    output dtct_pkg::cfg_view_t           view
);
    import dtct_pkg::*;

    logic [CNT_W-1:0]               target_count_reg, target_count_next;
    logic [CNT_W-1:0]               chain_count_reg, chain_count_next;
    logic [NUM_MAPS-1:0][MAP_W-1:0] chain_map_reg, chain_map_next;

    // Write decode; unknown indexes leave everything unchanged.
    always_comb
    begin
        target_count_next = target_count_reg;
        chain_count_next  = chain_count_reg;
        chain_map_next    = chain_map_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_TARGET_COUNT: target_count_next = wr_data[CNT_W-1:0];
                REG_CHAIN_COUNT:  chain_count_next  = wr_data[CNT_W-1:0];
                REG_CHAIN_MAP_0:  chain_map_next[0] = wr_data;
                REG_CHAIN_MAP_1:  chain_map_next[1] = wr_data;
                REG_CHAIN_MAP_2:  chain_map_next[2] = wr_data;
                REG_CHAIN_MAP_3:  chain_map_next[3] = wr_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= '0;
            chain_count_reg  <= '0;
            chain_map_reg    <= '0;
        end
        else
        begin
            target_count_reg <= target_count_next;
            chain_count_reg  <= chain_count_next;
            chain_map_reg    <= chain_map_next;
        end
    end

    // Lane masks: bit i is set when i is below the count. Counts above 32 cover all lanes.
    always_comb
    begin
        for (int i = 0; i < DATA_W; i++)
        begin
            view.target_mask[i] = CNT_W'(i) < target_count_reg;
            view.chain_mask[i]  = CNT_W'(i) < chain_count_reg;
        end
        view.no_chains = (chain_count_reg == '0);
        view.chain_map = chain_map_reg;
    end

endmodule

@@ design/dtct_update.sv @@
// Tracker state and per-frame update of the decode target chain tracker.
// Computes the result of one frame and advances the state on step; depends on dtct_pkg.
module dtct_update (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dtct_pkg::frame_t     frame,
    input  dtct_pkg::cfg_view_t  view,
    output dtct_pkg::result_t    result_next
);
    import dtct_pkg::*;

    logic [DATA_W-1:0] last_mask_reg, last_mask_next;
    logic [DATA_W-1:0] pending_reg, pending_next;
    logic [DATA_W-1:0] prev_member_reg, prev_member_next;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] member;
    logic [DATA_W-1:0] base_mask;
    logic [DATA_W-1:0] base_pending;
    logic [DATA_W-1:0] protect_set;

    // Chains that protect the active targets: one index decode per target lane.
    always_comb
    begin
        logic [IDX_W-1:0] idx;
        protect_set = '0;
        for (int dt = 0; dt < DATA_W; dt++)
        begin
            idx = view.chain_map[dt / TGT_PER_MAP][(dt % TGT_PER_MAP) * IDX_W +: IDX_W];
            if (view.target_mask[dt] && mask[dt] && !idx[IDX_W-1]
                && view.chain_mask[idx[IDX_W-2:0]])
            begin
                protect_set[idx[IDX_W-2:0]] = 1'b1;
            end
        end
    end

    // Frame mask and membership as seen through the configured counts.
    assign mask   = frame.targets_given ? (frame.active_targets | ~view.target_mask) : '1;
    assign member = frame.chain_membership & view.chain_mask;

    // A keyframe restarts; a delta frame retires the chains the last frame carried.
    assign base_mask    = frame.keyframe ? '1 : last_mask_reg;
    assign base_pending = frame.keyframe ? '0 : (pending_reg & ~prev_member_reg);

    // A changed mask reloads the pending set, or a dummy bit when there are no chains.
    always_comb
    begin
        last_mask_next   = base_mask;
        pending_next     = base_pending;
        prev_member_next = member;
        if (mask != base_mask)
        begin
            last_mask_next = mask;
            pending_next   = protect_set;
            if (view.no_chains)
            begin
                pending_next     = DATA_W'(1);
                prev_member_next = DATA_W'(1);
            end
        end
    end

    assign result_next.active_mask    = last_mask_next;
    assign result_next.pending_chains = pending_next;
    assign result_next.send_mask      = (pending_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mask_reg   <= '1;
            pending_reg     <= '0;
            prev_member_reg <= '0;
        end
        else if (step)
        begin
            last_mask_reg   <= last_mask_next;
            pending_reg     <= pending_next;
            prev_member_reg <= prev_member_next;
        end
    end

endmodule

@@ design/decode_target_chain_tracker.sv @@
// Top level of the decode target chain tracker: input register, update logic, result register.
// Depends on dtct_pkg, dtct_if, dtct_cfg and dtct_update.
//
//   Port     Direction  Moves
//   frame    sink       one frame descriptor per item
//   result   source     mask, pending chains and send flag per item
//   cfg      sink       register index and data per write
//
// Each item is held in the input register and leaves through the result register;
// a new item is taken every cycle while the result is not stalled.
// The update of the tracker state is the combinational path between the two registers.
// A stalled result holds the result register, and the input register fills behind it.
// Reset sets the stored mask to all ones and clears pending chains, valid flags and config registers.
// Config writes are taken every cycle.
module decode_target_chain_tracker (
    input  logic         clk,
    input  logic         rst_n,
    dtct_frame_if.sink   frame,
    dtct_result_if.source result,
    dtct_cfg_if.sink     cfg
);
    import dtct_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    frame_t    s1_frame_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   out_reg;
    result_t   result_next;
    cfg_view_t view;
    logic      advance;
    logic      step;
    logic      frame_fire;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    dtct_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .view     (view)
    );

    // Pipeline control: the result register frees up when empty or taken.
    assign advance     = !out_valid_reg || result.ready;
    assign step        = s1_valid_reg && advance;
    assign frame.ready = !s1_valid_reg || advance;
    assign frame_fire  = frame.valid && frame.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (frame_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            s1_frame_reg.active_targets   <= frame.active_targets;
            s1_frame_reg.targets_given    <= frame.targets_given;
            s1_frame_reg.keyframe         <= frame.keyframe;
            s1_frame_reg.chain_membership <= frame.chain_membership;
        end
    end

    // Tracker state and frame update.
    dtct_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .frame       (s1_frame_reg),
        .view        (view),
        .result_next (result_next)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.active_mask    = out_reg.active_mask;
    assign result.pending_chains = out_reg.pending_chains;
    assign result.send_mask      = out_reg.send_mask;

endmodule
